/* rtl/core/sha_pkg.sv */
`default_nettype none

package sha_pkg;

  // Block geometry
  localparam int unsigned BLOCK_BITS = 512;
  localparam int unsigned ROUNDS     = 64;

  // Buffer fill marks used by the padding sequence
  localparam logic [5:0] FILL_LAST      = 6'd63;
  localparam logic [5:0] FILL_LEN_START = 6'd56;

  // Padding marker byte
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Digest pieces
  localparam logic [1:0] PART_LAST = 2'd3;

  // Initial hash values
  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constants
  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Source of the byte shifted into the block buffer
  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       push;
    byte_sel_t  sel;
    logic       count_en;
    logic       len_load;
    logic       round_en;
    logic [5:0] round;
    logic       final_add;
    logic       reinit;
    logic [1:0] part;
  } sha_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [5:0] fill;
  } sha_sts_t;

endpackage

`default_nettype wire

/* rtl/core/sha_if.sv */
`default_nettype none

// Byte stream channel
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

// Digest channel
interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_part;
  logic [1:0]  part_index;
  logic        last_part;

  modport source (output valid, output digest_part, output part_index, output last_part,
                  input ready);
  modport sink   (input valid, input digest_part, input part_index, input last_part,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/sha256_byte_stream_hasher_top.sv */
// A data byte is taken in the idle state; the byte that fills a 64-byte block starts
// 64 rounds of the single round unit, then the hash feed-forward. No byte is taken
// while a block is compressed. Finish: padding bytes go in one per cycle while no
// block is compressed, with a pause in pushing before the length, 1 or 2 block
// compressions, then four digest beats. Reset is synchronous, active low; it loads
// the initial hash values and clears the fill and byte counts.
`default_nettype none

module sha256_byte_stream_hasher_top
  import sha_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);

  sha_cmd_t cmd;
  sha_sts_t sts;
  logic     in_ready;
  logic     out_valid;

  sha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sha_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_ch.data_byte),
    .sts         (sts),
    .digest_part (out_ch.digest_part)
  );

  // Drive the channel handshakes and beat tags
  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.part_index = cmd.part;
  assign out_ch.last_part  = (cmd.part == PART_LAST);

`ifndef NO_ASSERTIONS
  // Never take a byte while a digest beat is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input accepted while digest pending");

  // Beats after the first follow in order without a gap
  a_part_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last_part |=>
      out_ch.valid && (out_ch.part_index == $past(out_ch.part_index) + 2'd1))
    else $error("digest beat out of order");

  // Final beat leaves an empty buffer and the block ready for bytes
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last_part |=> (sts.fill == '0) && in_ch.ready)
    else $error("block not restarted after digest");
`endif

endmodule

`default_nettype wire

/* rtl/core/sha_dp.sv */
`default_nettype none

module sha_dp
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire sha_cmd_t    cmd,
  input  wire logic [7:0]  data_byte,
  output sha_sts_t         sts,
  output logic [63:0]      digest_part
);

  logic [31:0]           hash_r [8];
  logic [31:0]           work_r [8];
  logic [BLOCK_BITS-1:0] blk_r;
  logic [5:0]            fill_r;
  logic [60:0]           count_r;
  logic [63:0]           len_r;

  logic [7:0]  push_byte;
  logic [63:0] len_shift;
  logic [31:0] w0, w1, w9, w14, wnew;
  logic [31:0] t1, t2;
  logic [31:0] a, b, c, d, e, f, g, h;

  // Pick the byte to shift in
  assign len_shift = len_r << {fill_r[2:0], 3'b000};

  always_comb begin
    unique case (cmd.sel)
      SEL_DATA: push_byte = data_byte;
      SEL_PAD:  push_byte = PAD_BYTE;
      SEL_ZERO: push_byte = 8'h00;
      SEL_LEN:  push_byte = len_shift[63:56];
      default:  push_byte = 8'h00;
    endcase
  end

  // Message schedule window: oldest word at the top of the block buffer
  assign w0  = blk_r[511:480];
  assign w1  = blk_r[479:448];
  assign w9  = blk_r[223:192];
  assign w14 = blk_r[63:32];

  assign wnew = w0 + w9
              + ({w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3))
              + ({w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10));

  // One compression round
  assign a = work_r[0];
  assign b = work_r[1];
  assign c = work_r[2];
  assign d = work_r[3];
  assign e = work_r[4];
  assign f = work_r[5];
  assign g = work_r[6];
  assign h = work_r[7];

  assign t1 = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
            + ((e & f) ^ (~e & g)) + ROUND_K[cmd.round] + w0;
  assign t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
            + ((a & b) ^ (a & c) ^ (b & c));

  // Hash state, fill and byte count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r  <= SHA_IV;
      fill_r  <= '0;
      count_r <= '0;
    end else begin
      if (cmd.push) begin
        fill_r <= fill_r + 6'd1;
      end
      if (cmd.count_en) begin
        count_r <= count_r + 61'd1;
      end
      if (cmd.final_add) begin
        for (int i = 0; i < 8; i++) begin
          hash_r[i] <= hash_r[i] + work_r[i];
        end
      end
      if (cmd.reinit) begin
        hash_r  <= SHA_IV;
        fill_r  <= '0;
        count_r <= '0;
      end
    end
  end

  // Block buffer, working variables and latched bit length
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      blk_r <= {blk_r[BLOCK_BITS-9:0], push_byte};
    end
    if (cmd.push && fill_r == FILL_LAST) begin
      work_r <= hash_r;
    end
    if (cmd.len_load) begin
      len_r <= {count_r, 3'b000};
    end
    if (cmd.round_en) begin
      blk_r     <= {blk_r[BLOCK_BITS-33:0], wnew};
      work_r[0] <= t1 + t2;
      work_r[1] <= a;
      work_r[2] <= b;
      work_r[3] <= c;
      work_r[4] <= d + t1;
      work_r[5] <= e;
      work_r[6] <= f;
      work_r[7] <= g;
    end
  end

  assign sts.fill    = fill_r;
  assign digest_part = {hash_r[{cmd.part, 1'b0}], hash_r[{cmd.part, 1'b1}]};

endmodule

`default_nettype wire

/* rtl/core/sha_ctrl.sv */
`default_nettype none

module sha_ctrl
  import sha_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_kind,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire sha_sts_t sts,
  output sha_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_EMIT
  } state_t;

  // Where to resume once a block has been folded into the hash
  typedef enum logic [1:0] {
    PH_MSG,
    PH_ZERO,
    PH_LEN
  } phase_t;

  state_t     state_r;
  phase_t     phase_r;
  logic [5:0] round_r;
  logic [1:0] part_r;

  logic block_full;

  assign block_full = (sts.fill == FILL_LAST);

  // Decode commands from the current state
  always_comb begin
    cmd          = '0;
    cmd.sel      = SEL_DATA;
    cmd.round    = round_r;
    cmd.part     = part_r;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.push     = 1'b1;
          cmd.sel      = in_kind ? SEL_PAD : SEL_DATA;
          cmd.count_en = !in_kind;
          cmd.len_load = in_kind;
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
      end
      ST_FINAL: begin
        cmd.final_add = 1'b1;
      end
      ST_PAD_ZERO: begin
        if (sts.fill != FILL_LEN_START) begin
          cmd.push = 1'b1;
          cmd.sel  = SEL_ZERO;
        end
      end
      ST_PAD_LEN: begin
        cmd.push = 1'b1;
        cmd.sel  = SEL_LEN;
      end
      ST_EMIT: begin
        out_valid  = 1'b1;
        cmd.reinit = out_ready && (part_r == PART_LAST);
      end
      default: begin
      end
    endcase
  end

  // Sequence blocks, padding and digest beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_MSG;
      round_r <= '0;
      part_r  <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            phase_r <= in_kind ? PH_ZERO : PH_MSG;
            if (block_full) begin
              state_r <= ST_ROUND;
            end else if (in_kind) begin
              state_r <= ST_PAD_ZERO;
            end
          end
        end
        ST_ROUND: begin
          round_r <= round_r + 6'd1;
          if (round_r == 6'(ROUNDS - 1)) begin
            state_r <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          unique case (phase_r)
            PH_MSG:  state_r <= ST_IDLE;
            PH_ZERO: state_r <= ST_PAD_ZERO;
            PH_LEN: begin
              state_r <= ST_EMIT;
              part_r  <= '0;
            end
            default: state_r <= ST_IDLE;
          endcase
        end
        ST_PAD_ZERO: begin
          if (sts.fill == FILL_LEN_START) begin
            state_r <= ST_PAD_LEN;
            phase_r <= PH_LEN;
          end else if (block_full) begin
            state_r <= ST_ROUND;
          end
        end
        ST_PAD_LEN: begin
          if (block_full) begin
            state_r <= ST_ROUND;
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            if (part_r == PART_LAST) begin
              state_r <= ST_IDLE;
              phase_r <= PH_MSG;
            end else begin
              part_r <= part_r + 2'd1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
